### rtl/rtpd_pkg.sv
package rtpd_pkg;

    localparam int DATA_W       = 8;
    localparam int PTYPE_W      = 7;
    localparam int SKIP_W       = 19;
    localparam int PLEN_W       = 24;
    localparam int WORD_HOLD_W  = 24;
    localparam int OPT_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;
    localparam int QUEUE_DEPTH  = 2;

    // bytes of the fixed RTP header left to skip after its first word
    localparam logic [SKIP_W-1:0] RTP_FIXED_SKIP = SKIP_W'(8);
    localparam logic [SKIP_W-1:0] WORD_BYTES     = SKIP_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ASF_TYPE_CODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ASF_PARSE_ENABLE = 1'd1;

    localparam logic [PTYPE_W-1:0] ASF_TYPE_RESET   = 7'h60;
    localparam logic               ASF_ENABLE_RESET = 1'b1;

    // result status codes
    localparam logic STATUS_PAYLOAD = 1'b0;
    localparam logic STATUS_CUT     = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_FIXSKIP,
        PH_EXTHDR,
        PH_EXTSKIP,
        PH_ASFHDR,
        PH_ASFSKIP,
        PH_PLAIN,
        PH_COUNTED
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              datagram_end;
    } qent_t;

    typedef struct packed {
        logic [PTYPE_W-1:0] asf_type_code;
        logic               asf_parse_enable;
    } asf_cfg_t;

endpackage

### rtl/rtpd_if.sv
interface rtpd_in_if;
    logic                       valid;
    logic                       ready;
    logic [rtpd_pkg::DATA_W-1:0] data_byte;
    logic                       datagram_end;

    modport source (output valid, output data_byte, output datagram_end, input ready);
    modport sink   (input valid, input data_byte, input datagram_end, output ready);
endinterface

interface rtpd_out_if;
    logic                        valid;
    logic                        ready;
    logic [rtpd_pkg::DATA_W-1:0]  payload_byte;
    logic [rtpd_pkg::PTYPE_W-1:0] payload_kind;
    logic                        marker_bit;
    logic                        status;
    logic                        last_of_payload;

    modport source (output valid, output payload_byte, output payload_kind,
                    output marker_bit, output status, output last_of_payload,
                    input ready);
    modport sink   (input valid, input payload_byte, input payload_kind,
                    input marker_bit, input status, input last_of_payload,
                    output ready);
endinterface

### rtl/rtp_depacketizer_unit.sv
// RTP depacketizer: takes a UDP datagram one byte per transaction on rx (datagram_end marks
// the last byte) and returns one transaction on tx for each RTP payload byte, tagged with
// payload type and marker bit, with last_of_payload set on the final byte of each packet.
// Fixed header, CSRC words, extension header and, for the configured payload type, the ASF
// header with its optional skips produce no output. A datagram that ends inside headers
// yields a single error transaction (status 1, last_of_payload 1, other fields zero).
// Throughput is one byte per clock cycle while tx is ready; a tx stall holds the parser.
// The byte parser advances one state step per byte. A byte passes through the input queue
// and then the output register on its way from rx to tx. The queue (QUEUE_DEPTH entries)
// and the output register let rx and tx stall independently. Write configuration
// only while no transaction is in flight.
module rtp_depacketizer_unit #(
    parameter int QUEUE_DEPTH = rtpd_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rtpd_in_if.sink                         rx,
    rtpd_out_if.source                      tx,
    input  logic                            cfg_we,
    input  logic [rtpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtpd_pkg::CFG_DATA_W-1:0] cfg_data
);

    rtpd_pkg::asf_cfg_t cfg_reg, cfg_next;
    rtpd_pkg::qent_t    head;
    logic               head_valid;
    logic               pop;

    // Register file: decode the index, hold the value otherwise.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rtpd_pkg::REG_ASF_TYPE_CODE:
                begin
                    cfg_next.asf_type_code = cfg_data[rtpd_pkg::PTYPE_W-1:0];
                end
                rtpd_pkg::REG_ASF_PARSE_ENABLE:
                begin
                    cfg_next.asf_parse_enable = cfg_data[0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.asf_type_code    <= rtpd_pkg::ASF_TYPE_RESET;
            cfg_reg.asf_parse_enable <= rtpd_pkg::ASF_ENABLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept bytes into the queue.
    rtpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // Back: parse headers, drop them, emit payload bytes.
    rtpd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .tx         (tx)
    );

endmodule

### rtl/rtpd_queue.sv
module rtpd_queue #(
    parameter int DEPTH = rtpd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    rtpd_in_if.sink         rx,
    output rtpd_pkg::qent_t head,
    output logic            head_valid,
    input  logic            pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtpd_pkg::qent_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign rx.ready   = (count_reg != CNT_W'(DEPTH));
    assign push       = rx.valid && rx.ready;
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{data_byte: rx.data_byte, datagram_end: rx.datagram_end};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

### rtl/rtpd_parser.sv
module rtpd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  rtpd_pkg::asf_cfg_t cfg,
    input  rtpd_pkg::qent_t    head,
    input  logic               head_valid,
    output logic               pop,
    rtpd_out_if.source         tx
);

    rtpd_pkg::phase_t                     phase_reg, phase_next;
    logic [rtpd_pkg::WORD_HOLD_W-1:0]     word_reg, word_next;
    logic [rtpd_pkg::SKIP_W-1:0]          skip_reg, skip_next;
    logic [rtpd_pkg::PLEN_W-1:0]          left_reg, left_next;
    logic [rtpd_pkg::PTYPE_W-1:0]         type_reg, type_next;
    logic                                 marker_reg, marker_next;
    logic [rtpd_pkg::OPT_W-1:0]           opt_reg, opt_next;
    logic                                 ext_reg, ext_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [rtpd_pkg::DATA_W-1:0]          out_byte_reg, out_byte_next;
    logic [rtpd_pkg::PTYPE_W-1:0]         out_kind_reg, out_kind_next;
    logic                                 out_marker_reg, out_marker_next;
    logic                                 out_status_reg, out_status_next;
    logic                                 out_last_reg, out_last_next;

    logic [31:0]                          word;
    logic [rtpd_pkg::SKIP_W-1:0]          skip_inc, skip_dec;
    logic [rtpd_pkg::PLEN_W-1:0]          left_dec;
    logic                                 asf_hit;
    logic                                 emit, cut, last;
    logic [1:0]                           opt_cnt;

    assign pop      = head_valid && (!out_valid_reg || tx.ready);
    assign word     = {word_reg, head.data_byte};
    assign skip_inc = skip_reg + 1'b1;
    assign skip_dec = skip_reg - 1'b1;
    assign left_dec = left_reg - 1'b1;
    assign asf_hit  = cfg.asf_parse_enable && (type_reg == cfg.asf_type_code);
    assign opt_cnt  = 2'(word[29]) + 2'(word[28]) + 2'(word[27]);

    always_comb
    begin
        phase_next  = phase_reg;
        word_next   = word_reg;
        skip_next   = skip_reg;
        left_next   = left_reg;
        type_next   = type_reg;
        marker_next = marker_reg;
        opt_next    = opt_reg;
        ext_next    = ext_reg;
        emit        = 1'b0;
        cut         = 1'b0;
        last        = head.datagram_end;

        unique case (phase_reg)
            rtpd_pkg::PH_PLAIN, rtpd_pkg::PH_COUNTED:
            begin
                emit = 1'b1;
                if (phase_reg == rtpd_pkg::PH_COUNTED)
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        last       = 1'b1;
                        phase_next = rtpd_pkg::PH_HDR;
                        skip_next  = '0;
                    end
                end
            end
            rtpd_pkg::PH_HDR:
            begin
                word_next = word[rtpd_pkg::WORD_HOLD_W-1:0];
                skip_next = skip_inc;
                if (skip_inc >= rtpd_pkg::WORD_BYTES)
                begin
                    type_next   = word[22:16];
                    marker_next = word[23];
                    ext_next    = word[28];
                    skip_next   = rtpd_pkg::RTP_FIXED_SKIP
                                + rtpd_pkg::SKIP_W'({word[27:24], 2'b00});
                    phase_next  = rtpd_pkg::PH_FIXSKIP;
                end
            end
            rtpd_pkg::PH_FIXSKIP, rtpd_pkg::PH_EXTSKIP, rtpd_pkg::PH_ASFSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    if (phase_reg == rtpd_pkg::PH_FIXSKIP && ext_reg)
                    begin
                        phase_next = rtpd_pkg::PH_EXTHDR;
                    end
                    else if (phase_reg == rtpd_pkg::PH_ASFSKIP)
                    begin
                        phase_next = !opt_reg[3] ? rtpd_pkg::PH_PLAIN :
                                     (left_reg == '0) ? rtpd_pkg::PH_HDR :
                                     rtpd_pkg::PH_COUNTED;
                    end
                    else
                    begin
                        phase_next = asf_hit ? rtpd_pkg::PH_ASFHDR : rtpd_pkg::PH_PLAIN;
                    end
                end
            end
            rtpd_pkg::PH_EXTHDR:
            begin
                word_next = word[rtpd_pkg::WORD_HOLD_W-1:0];
                skip_next = skip_inc;
                if (skip_inc >= rtpd_pkg::WORD_BYTES)
                begin
                    skip_next = rtpd_pkg::SKIP_W'({word[15:0], 2'b00});
                    if (word[15:0] == '0)
                    begin
                        phase_next = asf_hit ? rtpd_pkg::PH_ASFHDR : rtpd_pkg::PH_PLAIN;
                    end
                    else
                    begin
                        phase_next = rtpd_pkg::PH_EXTSKIP;
                    end
                end
            end
            rtpd_pkg::PH_ASFHDR:
            begin
                word_next = word[rtpd_pkg::WORD_HOLD_W-1:0];
                skip_next = skip_inc;
                if (skip_inc >= rtpd_pkg::WORD_BYTES)
                begin
                    opt_next  = word[30:27];
                    left_next = word[23:0];
                    skip_next = rtpd_pkg::SKIP_W'({opt_cnt, 2'b00});
                    if (opt_cnt == '0)
                    begin
                        phase_next = !word[30] ? rtpd_pkg::PH_PLAIN :
                                     (word[23:0] == '0) ? rtpd_pkg::PH_HDR :
                                     rtpd_pkg::PH_COUNTED;
                    end
                    else
                    begin
                        phase_next = rtpd_pkg::PH_ASFSKIP;
                    end
                end
            end
        endcase

        if (head.datagram_end)
        begin
            // headers left unfinished at the end of the datagram give one error result
            cut = !emit && !(phase_next == rtpd_pkg::PH_PLAIN
                          || phase_next == rtpd_pkg::PH_COUNTED
                          || (phase_next == rtpd_pkg::PH_HDR && skip_next == '0));
            phase_next = rtpd_pkg::PH_HDR;
            word_next  = '0;
            skip_next  = '0;
            left_next  = '0;
            opt_next   = '0;
            ext_next   = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_kind_next   = out_kind_reg;
        out_marker_next = out_marker_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (!out_valid_reg || tx.ready)
        begin
            out_valid_next = pop && (emit || cut);
        end
        if (pop)
        begin
            out_byte_next   = cut ? '0 : head.data_byte;
            out_kind_next   = cut ? '0 : type_reg;
            out_marker_next = cut ? 1'b0 : marker_reg;
            out_status_next = cut ? rtpd_pkg::STATUS_CUT : rtpd_pkg::STATUS_PAYLOAD;
            out_last_next   = cut || last;
        end
    end

    assign tx.valid           = out_valid_reg;
    assign tx.payload_byte    = out_byte_reg;
    assign tx.payload_kind    = out_kind_reg;
    assign tx.marker_bit      = out_marker_reg;
    assign tx.status          = out_status_reg;
    assign tx.last_of_payload = out_last_reg;

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_kind_reg   <= out_kind_next;
        out_marker_reg <= out_marker_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        word_reg       <= pop ? word_next : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rtpd_pkg::PH_HDR;
            skip_reg      <= '0;
            left_reg      <= '0;
            type_reg      <= '0;
            marker_reg    <= 1'b0;
            opt_reg       <= '0;
            ext_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg  <= phase_next;
                skip_reg   <= skip_next;
                left_reg   <= left_next;
                type_reg   <= type_next;
                marker_reg <= marker_next;
                opt_reg    <= opt_next;
                ext_reg    <= ext_next;
            end
        end
    end

    a_cut_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.status == rtpd_pkg::STATUS_CUT)
            |-> (tx.last_of_payload && tx.payload_byte == '0 && tx.payload_kind == '0))
        else $error("error result carries payload fields");

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rtpd_pkg::PH_COUNTED) |-> (left_reg != '0))
        else $error("counted payload phase with nothing left");

    a_collect_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rtpd_pkg::PH_HDR || phase_reg == rtpd_pkg::PH_EXTHDR
            || phase_reg == rtpd_pkg::PH_ASFHDR) |-> (skip_reg < rtpd_pkg::WORD_BYTES))
        else $error("header byte count out of range");

    a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rtpd_pkg::PH_FIXSKIP || phase_reg == rtpd_pkg::PH_EXTSKIP
            || phase_reg == rtpd_pkg::PH_ASFSKIP) |-> (skip_reg != '0))
        else $error("skip phase with zero count");

endmodule
